// ===== sv/annexb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package annexb_pkg;

  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);

  localparam logic [4:0] KindMask = 5'h1F;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       unit_first;
    logic       unit_last;
    logic [4:0] unit_kind;
    logic       run_end;
  } out_word_t;

  // Work for the back end: zero bytes, then optionally one byte, then optionally a unit close.
  typedef struct packed {
    logic [2:0] zeros;
    logic       has_byte;
    logic [7:0] value;
    logic       close_unit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/annexb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module annexb_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  annexb_pkg::in_word_t item,
  output logic                 cmd_valid,
  output annexb_pkg::cmd_t     cmd
);
  import annexb_pkg::*;

  logic       in_unit;
  logic       in_unit_next;
  logic [1:0] held;
  logic [1:0] held_next;
  logic       code;

  assign code = (item.stream_byte == 8'd1) &&
                ((held == 2'd3) || ((held == 2'd2) && !item.buffer_end));

  always_comb begin
    cmd          = '0;
    cmd.value    = item.stream_byte;
    in_unit_next = in_unit;
    held_next    = held;
    if (!in_unit) begin
      if (item.stream_byte == 8'd0) begin
        if (held != 2'd3) held_next = held + 2'd1;
      end else begin
        held_next = 2'd0;
        if (code) in_unit_next = 1'b1;
      end
    end else if (item.stream_byte == 8'd0) begin
      if (held == 2'd3) begin
        cmd.zeros = 3'd1;
      end else begin
        held_next = held + 2'd1;
      end
      if (item.buffer_end) begin
        cmd.zeros      = cmd.zeros + {1'b0, held_next};
        cmd.close_unit = 1'b1;
      end
    end else if (code) begin
      held_next      = 2'd0;
      cmd.close_unit = 1'b1;
    end else begin
      cmd.zeros      = {1'b0, held};
      cmd.has_byte   = 1'b1;
      held_next      = 2'd0;
      cmd.close_unit = item.buffer_end;
    end
    cmd_valid = accept && in_unit &&
                ((cmd.zeros != 3'd0) || cmd.has_byte || cmd.close_unit);
    if (item.buffer_end) begin
      in_unit_next = 1'b0;
      held_next    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_unit <= 1'b0;
      held    <= 2'd0;
    end else if (accept) begin
      in_unit <= in_unit_next;
      held    <= held_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/annexb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module annexb_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               wr_en,
  input  annexb_pkg::cmd_t  wr_data,
  input  wire               rd_en,
  output annexb_pkg::cmd_t  rd_data,
  output logic              not_empty,
  output logic              q_full
);
  import annexb_pkg::*;

  cmd_t              slots [QDepth];
  logic [QAddrW-1:0] wr_ptr;
  logic [QAddrW-1:0] rd_ptr;
  logic [QAddrW:0]   count;

  assign rd_data   = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign q_full    = (count == (QAddrW + 1)'(QDepth));

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/annexb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module annexb_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   head_valid,
  input  annexb_pkg::cmd_t      head,
  output logic                  head_pop,
  output logic                  empty,
  input  wire                   pop,
  output annexb_pkg::out_word_t result
);
  import annexb_pkg::*;

  logic       pend_valid;
  logic [7:0] pend_value;
  logic       pend_first;
  logic       expect_first;
  logic [4:0] kind;
  logic [2:0] step;
  logic       out_valid;
  out_word_t  out_word;

  logic [2:0] n_data;
  logic [2:0] n_steps;
  logic       is_data;
  logic [7:0] data;
  logic       emit;
  logic       out_free;
  logic       advance;
  logic       last_step;

  assign n_data    = head.zeros + {2'b0, head.has_byte};
  assign n_steps   = n_data + {2'b0, head.close_unit};
  assign is_data   = (step < n_data);
  assign data      = (step < head.zeros) ? 8'd0 : head.value;
  assign emit      = head_valid && pend_valid;
  assign out_free  = !out_valid || pop;
  assign advance   = head_valid && (!emit || out_free);
  assign last_step = (step == n_steps - 3'd1);
  assign head_pop  = advance && last_step;

  assign empty  = !out_valid;
  assign result = out_word;

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_word.payload_byte <= pend_value;
      out_word.unit_first   <= pend_first;
      out_word.unit_last    <= !is_data;
      out_word.unit_kind    <= kind;
      out_word.run_end      <= last_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      pend_value   <= 8'd0;
      pend_first   <= 1'b0;
      expect_first <= 1'b1;
      kind         <= 5'd0;
      step         <= 3'd0;
    end else begin
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        step <= last_step ? 3'd0 : step + 3'd1;
        if (is_data) begin
          pend_valid <= 1'b1;
          pend_value <= data;
          pend_first <= expect_first;
          if (expect_first) begin
            kind         <= data[4:0] & KindMask;
            expect_first <= 1'b0;
          end
        end else begin
          pend_valid   <= 1'b0;
          expect_first <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/annexb_nal_unit_splitter.sv =====
// Path: a byte is classified at its accept edge and its command queued; the back end
//   holds each unit's newest byte until its next byte or unit close, then registers it out.
// Throughput: one byte per cycle while the queue is not full; the back end works a step at a
//   time (held zeros, own byte, unit close); the 4-deep command queue absorbs the difference.
// Reset: synchronous, active high; clears queue, output register and all parsing state.
`timescale 1ns / 1ps
`default_nettype none

module annexb_nal_unit_splitter (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  output logic                  full,
  input  annexb_pkg::in_word_t  item,
  output logic                  empty,
  input  wire                   pop,
  output annexb_pkg::out_word_t result
);
  import annexb_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t head;
  logic head_valid;
  logic head_pop;

  assign accept = push && !full;

  annexb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  annexb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_valid),
    .wr_data   (cmd),
    .rd_en     (head_pop),
    .rd_data   (head),
    .not_empty (head_valid),
    .q_full    (full)
  );

  annexb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire

// ===== sv/annexb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module annexb_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   push,
  input wire                   full,
  input annexb_pkg::in_word_t  item,
  input wire                   empty,
  input wire                   pop,
  input annexb_pkg::out_word_t result
);
  import annexb_pkg::*;

  logic mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (pop && !empty) begin
      mid <= !result.unit_last;
    end
  end

  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not empty or full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting word changed");

  a_first_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.unit_first) |-> (result.unit_kind == result.payload_byte[4:0]))
    else $error("unit kind does not match first byte");

  a_framing: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.unit_first == !mid))
    else $error("unit first/last framing broken");

  a_known_word: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !$isunknown(item))
    else $error("unknown word accepted");

endmodule

bind annexb_nal_unit_splitter annexb_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .item   (item),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
